### hw/rtl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude core.
package sem_pkg;

  localparam int GREEN_W      = 8;
  localparam int MAG_W        = 11;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int ROW_W        = 13;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int MAX_HEIGHT   = 4096;
  localparam int GRAD_W       = 11;
  localparam int SQ_W         = 20;
  localparam int RAD_W        = 21;

  localparam logic [CFG_INDEX_W-1:0]  REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0]  REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET      = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET     = 13'd480;
  localparam logic                    KIND_PIXEL       = 1'b0;
  localparam logic                    KIND_FLUSH       = 1'b1;
  localparam logic [RAD_W-1:0]        ROOT_START       = 21'h100000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_GRAD,
    S_SQUARE,
    S_LOAD,
    S_ROOT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic grad;
    logic square;
    logic load;
    logic root_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_result;
    logic root_last;
  } dp_status_t;

endpackage

### hw/rtl/sem_in_if.sv
// Pixel request channel: valid, ready and one pixel or flush item.
interface sem_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [sem_pkg::GREEN_W-1:0] green;

  modport source (output valid, output kind, output green, input ready);
  modport sink (input valid, input kind, input green, output ready);
endinterface

### hw/rtl/sem_out_if.sv
// Result request channel: valid, ready and one gradient magnitude with position flags.
interface sem_out_if;
  logic                      valid;
  logic                      ready;
  logic [sem_pkg::MAG_W-1:0] magnitude;
  logic                      row_end;
  logic                      frame_end;

  modport source (output valid, output magnitude, output row_end, output frame_end,
                  input ready);
  modport sink (input valid, input magnitude, input row_end, input frame_end,
                output ready);
endinterface

### hw/rtl/sem_datapath.sv
// Datapath: config registers, raster counters, line stores, window, gradient and square root.
module sem_datapath #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sem_pkg::ctrl_cmd_t              cmd,
  output sem_pkg::dp_status_t             status,
  input  logic                            cfg_we,
  input  logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_kind,
  input  logic [sem_pkg::GREEN_W-1:0]     in_green,
  output logic [sem_pkg::MAG_W-1:0]       magnitude,
  output logic                            row_end,
  output logic                            frame_end
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > sem_pkg::WIDTH_REG_W) ? WW : sem_pkg::WIDTH_REG_W;

  logic [sem_pkg::WIDTH_REG_W-1:0]  image_width;
  logic [sem_pkg::HEIGHT_REG_W-1:0] image_height;
  logic [AW-1:0]                    column_count;
  logic [sem_pkg::ROW_W-1:0]        row_count;

  logic                        item_kind;
  logic [sem_pkg::GREEN_W-1:0] item_green;
  logic [sem_pkg::GREEN_W-1:0] rd_upper;
  logic [sem_pkg::GREEN_W-1:0] rd_middle;
  logic [sem_pkg::GREEN_W-1:0] upper_mem [MAX_WIDTH];
  logic [sem_pkg::GREEN_W-1:0] middle_mem [MAX_WIDTH];
  logic [sem_pkg::GREEN_W-1:0] win [3][3];

  logic zero_left;
  logic zero_right;
  logic row_flag;
  logic frame_flag;

  logic signed [sem_pkg::GRAD_W-1:0] gx;
  logic signed [sem_pkg::GRAD_W-1:0] gy;
  logic [sem_pkg::SQ_W-1:0]          sx;
  logic [sem_pkg::SQ_W-1:0]          sy;
  logic [sem_pkg::RAD_W-1:0]         rad;
  logic [sem_pkg::RAD_W-1:0]         root;
  logic [sem_pkg::RAD_W-1:0]         root_bit;

  logic [CW-1:0]                    width_ext;
  logic [WW-1:0]                    eff_w;
  logic [sem_pkg::HEIGHT_REG_W-1:0] eff_h;
  logic [sem_pkg::ROW_W-1:0]        h_plus;
  logic [sem_pkg::ROW_W-1:0]        row_inc;
  logic [WW-1:0]                    ci_inc;
  logic                             ci_zero;
  logic                             ci_one;
  logic                             row_ge1;
  logic                             row_ge2;
  logic                             row_in_mid;
  logic                             has_result;
  logic                             fend;
  logic                             cfg_hit;
  logic [sem_pkg::GREEN_W-1:0]      nv;
  logic [sem_pkg::GREEN_W-1:0]      up;
  logic [sem_pkg::GREEN_W-1:0]      md;

  logic [sem_pkg::GREEN_W-1:0]       pm [3][3];
  logic [sem_pkg::GRAD_W-2:0]        gx_pos;
  logic [sem_pkg::GRAD_W-2:0]        gx_neg;
  logic [sem_pkg::GRAD_W-2:0]        gy_pos;
  logic [sem_pkg::GRAD_W-2:0]        gy_neg;
  logic signed [sem_pkg::GRAD_W-1:0] gx_next;
  logic signed [sem_pkg::GRAD_W-1:0] gy_next;
  logic signed [2*sem_pkg::GRAD_W-1:0] gx_sq;
  logic signed [2*sem_pkg::GRAD_W-1:0] gy_sq;
  logic [sem_pkg::RAD_W:0]           trial;
  logic                              take;

  assign width_ext = CW'(image_width);

  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_ext);
    end
    if (image_height == '0) begin
      eff_h = sem_pkg::HEIGHT_REG_W'(1);
    end else if (image_height > sem_pkg::HEIGHT_REG_W'(sem_pkg::MAX_HEIGHT)) begin
      eff_h = sem_pkg::HEIGHT_REG_W'(sem_pkg::MAX_HEIGHT);
    end else begin
      eff_h = image_height;
    end
  end

  assign h_plus     = eff_h + sem_pkg::ROW_W'(1);
  assign row_inc    = row_count + sem_pkg::ROW_W'(1);
  assign ci_inc     = WW'(column_count) + WW'(1);
  assign ci_zero    = (column_count == '0);
  assign ci_one     = (column_count == AW'(1));
  assign row_ge1    = (row_count != '0);
  assign row_ge2    = (row_count >= sem_pkg::ROW_W'(2));
  assign row_in_mid = row_ge1 && (row_count <= eff_h);
  assign has_result = ci_zero ? row_ge2 : row_in_mid;
  assign fend       = ci_zero && (row_count == h_plus);
  assign cfg_hit    = cfg_we && (cfg_index == sem_pkg::REG_IMAGE_WIDTH ||
                                 cfg_index == sem_pkg::REG_IMAGE_HEIGHT);

  assign nv = (item_kind == sem_pkg::KIND_PIXEL && row_count < eff_h) ? item_green : '0;
  assign up = row_ge2 ? rd_upper : '0;
  assign md = row_in_mid ? rd_middle : '0;

  assign status.has_result = has_result;
  assign status.root_last  = root_bit[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sem_pkg::WIDTH_RESET;
      image_height <= sem_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sem_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[sem_pkg::WIDTH_REG_W-1:0];
        sem_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.update) begin
      if (has_result && fend) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (ci_inc >= eff_w) begin
        column_count <= '0;
        row_count    <= row_inc;
      end else begin
        column_count <= AW'(ci_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_kind  <= in_kind;
      item_green <= in_green;
      rd_upper   <= upper_mem[column_count];
      rd_middle  <= middle_mem[column_count];
    end
    if (cmd.update) begin
      upper_mem[column_count]  <= md;
      middle_mem[column_count] <= nv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (cmd.update) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= up;
      win[1][2] <= md;
      win[2][2] <= nv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      zero_left  <= ci_zero ? (eff_w < WW'(2)) : ci_one;
      zero_right <= ci_zero;
      row_flag   <= ci_zero;
      frame_flag <= fend;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((c == 0 && zero_left) || (c == 2 && zero_right)) begin
          pm[r][c] = '0;
        end else begin
          pm[r][c] = win[r][c];
        end
      end
    end
  end

  assign gx_pos = {2'b00, pm[0][2]} + {1'b0, pm[1][2], 1'b0} + {2'b00, pm[2][2]};
  assign gx_neg = {2'b00, pm[0][0]} + {1'b0, pm[1][0], 1'b0} + {2'b00, pm[2][0]};
  assign gy_pos = {2'b00, pm[2][0]} + {1'b0, pm[2][1], 1'b0} + {2'b00, pm[2][2]};
  assign gy_neg = {2'b00, pm[0][0]} + {1'b0, pm[0][1], 1'b0} + {2'b00, pm[0][2]};
  assign gx_next = signed'({1'b0, gx_pos}) - signed'({1'b0, gx_neg});
  assign gy_next = signed'({1'b0, gy_pos}) - signed'({1'b0, gy_neg});
  assign gx_sq   = gx * gx;
  assign gy_sq   = gy * gy;

  assign trial = {1'b0, root} + {1'b0, root_bit};
  assign take  = ({1'b0, rad} >= trial);

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      gx <= gx_next;
      gy <= gy_next;
    end
    if (cmd.square) begin
      sx <= gx_sq[sem_pkg::SQ_W-1:0];
      sy <= gy_sq[sem_pkg::SQ_W-1:0];
    end
    if (cmd.load) begin
      rad      <= {1'b0, sx} + {1'b0, sy};
      root     <= '0;
      root_bit <= sem_pkg::ROOT_START;
    end else if (cmd.root_step) begin
      if (take) begin
        rad  <= rad - trial[sem_pkg::RAD_W-1:0];
        root <= (root >> 1) + root_bit;
      end else begin
        root <= root >> 1;
      end
      root_bit <= root_bit >> 2;
    end
    if (cmd.out_load) begin
      magnitude <= root[sem_pkg::MAG_W-1:0];
      row_end   <= row_flag;
      frame_end <= frame_flag;
    end
  end

endmodule

### hw/rtl/sem_controller.sv
// Controller: sequences one item through update and, if it yields a result, gradient, square, load and root steps.
module sem_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  sem_pkg::dp_status_t status,
  output sem_pkg::ctrl_cmd_t  cmd
);

  sem_pkg::state_t state;
  sem_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sem_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sem_pkg::S_IDLE:   if (in_valid) state_next = sem_pkg::S_UPDATE;
      sem_pkg::S_UPDATE: state_next = status.has_result ? sem_pkg::S_GRAD : sem_pkg::S_IDLE;
      sem_pkg::S_GRAD:   state_next = sem_pkg::S_SQUARE;
      sem_pkg::S_SQUARE: state_next = sem_pkg::S_LOAD;
      sem_pkg::S_LOAD:   state_next = sem_pkg::S_ROOT;
      sem_pkg::S_ROOT:   if (status.root_last) state_next = sem_pkg::S_DONE;
      sem_pkg::S_DONE:   if (out_free) state_next = sem_pkg::S_IDLE;
      default:           state_next = sem_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      sem_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      sem_pkg::S_UPDATE: cmd.update    = 1'b1;
      sem_pkg::S_GRAD:   cmd.grad      = 1'b1;
      sem_pkg::S_SQUARE: cmd.square    = 1'b1;
      sem_pkg::S_LOAD:   cmd.load      = 1'b1;
      sem_pkg::S_ROOT:   cmd.root_step = 1'b1;
      sem_pkg::S_DONE:   cmd.out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### hw/rtl/sobel_edge_magnitude_core.sv
// Top level of the streaming 3x3 Sobel gradient magnitude core.
//
// Pixel channel (valid/ready): one item per request, kind 0 = image pixel with its green
// byte, kind 1 = flush item. Items arrive in raster order; after the last pixel of a frame
// send image_width + 1 flush items so the last row drains.
// Result channel (valid/ready): floor(sqrt(gx*gx + gy*gy)) with row_end and frame_end,
// in raster order, one row and one pixel behind the input.
// Config port: cfg_we with cfg_index 0 = image_width, 1 = image_height; a write to either of
// them restarts the frame. Write only while the core is idle.
// Steps per item: an item that yields no result passes the line store read and window
// update only; one that yields a result then also runs gradient, square, load, the
// bit-per-cycle square root unit (11 steps) and the output load, one item at a time.
// A single output register holds the result while the receiver stalls; the next item is
// accepted and processed meanwhile, and only its final hand-off waits.
// Reset: counters, window and config defaults (640 x 480) restored; line stores are not
// cleared, rows outside the image are masked.
module sobel_edge_magnitude_core #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data,
  sem_in_if.sink                          pixel,
  sem_out_if.source                       result
);

  sem_pkg::ctrl_cmd_t        cmd;
  sem_pkg::dp_status_t       status;
  logic                      in_ready;
  logic                      out_valid;
  logic [sem_pkg::MAG_W-1:0] magnitude;
  logic                      row_end;
  logic                      frame_end;

  sem_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel.valid),
    .in_ready  (in_ready),
    .out_ready (result.ready),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  sem_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_kind   (pixel.kind),
    .in_green  (pixel.green),
    .magnitude (magnitude),
    .row_end   (row_end),
    .frame_end (frame_end)
  );

  assign pixel.ready      = in_ready;
  assign result.valid     = out_valid;
  assign result.magnitude = magnitude;
  assign result.row_end   = row_end;
  assign result.frame_end = frame_end;

endmodule

### hw/rtl/sem_checker.sv
// Port-level assertions for the Sobel edge magnitude core and their bind.
module sem_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [sem_pkg::MAG_W-1:0] magnitude,
  input logic                      row_end,
  input logic                      frame_end
);

  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> magnitude <= sem_pkg::MAG_W'(1442))
    else $error("magnitude above 1442");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> row_end)
    else $error("frame_end without row_end");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(magnitude) && $stable(row_end) &&
                                $stable(frame_end))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous item in work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sobel_edge_magnitude_core sem_checker u_sem_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel.valid),
  .in_ready  (pixel.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .magnitude (result.magnitude),
  .row_end   (result.row_end),
  .frame_end (result.frame_end)
);

### verif/sobel_edge_magnitude_core_tb.sv
// Self-checking testbench: streams random and directed frames, predicts each Sobel magnitude.
module sobel_edge_magnitude_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LINE        = 2048;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_CYCLES     = 400;
  localparam int WELL_FORMED_PCT = 92;
  localparam int PRINT_CAP       = 50;
  localparam int EXTREME_ITEMS   = 25;
  localparam logic [sem_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [sem_pkg::MAG_W-1:0] magnitude;
    logic                      row_end;
    logic                      frame_end;
  } edge_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data;

  sem_in_if  pix_if ();
  sem_out_if res_if ();

  sobel_edge_magnitude_core #(
    .MAX_WIDTH(MAX_LINE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pixel    (pix_if),
    .result   (res_if)
  );

  // Shadow of the core: registers, line stores, window and raster position.
  logic [sem_pkg::WIDTH_REG_W-1:0]  width_shadow;
  logic [sem_pkg::HEIGHT_REG_W-1:0] height_shadow;
  logic [sem_pkg::GREEN_W-1:0]      upper_line [MAX_LINE];
  logic [sem_pkg::GREEN_W-1:0]      middle_line [MAX_LINE];
  logic [sem_pkg::GREEN_W-1:0]      win [3][3];
  int unsigned                      col_pos;
  int unsigned                      row_pos;

  edge_result_t due_gradients [$];

  int send_idle_pct;
  int stall_pct;
  int holds_requested;
  int pixels_sent;
  int gradients_checked;
  int frames_closed;
  int mismatch_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d gradients outstanding", due_gradients.size());
    $display("Regression FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("MISMATCH @%0t: %s", $realtime, what);
    end
  endtask

  function automatic int unsigned eff_cols();
    if (width_shadow == 0) return 1;
    if (width_shadow > MAX_LINE) return MAX_LINE;
    return width_shadow;
  endfunction

  function automatic int unsigned eff_rows();
    if (height_shadow == 0) return 1;
    if (height_shadow > sem_pkg::MAX_HEIGHT) return sem_pkg::MAX_HEIGHT;
    return height_shadow;
  endfunction

  function automatic int frame_len();
    return eff_cols() * eff_rows() + eff_cols() + 1;
  endfunction

  function automatic logic [sem_pkg::MAG_W-1:0] floor_root(input int unsigned v);
    int unsigned root;
    int unsigned trial;
    int b;
    root = 0;
    for (b = sem_pkg::MAG_W - 1; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[sem_pkg::MAG_W-1:0];
  endfunction

  // Advance the shadow by one request; return 1 when a gradient falls due.
  function automatic bit sobel_advance(input logic kind,
                                       input logic [sem_pkg::GREEN_W-1:0] green,
                                       output edge_result_t res);
    int unsigned w, h, ci, ri;
    logic [sem_pkg::GREEN_W-1:0] nv, up, md;
    int taps [3][3];
    bit hit, last_col, last_row;
    int gx, gy;
    int r, c;
    w  = eff_cols();
    h  = eff_rows();
    ci = col_pos;
    ri = row_pos;
    res = '0;
    nv = (kind == sem_pkg::KIND_PIXEL && ri < h) ? green : '0;
    up = (ri >= 2) ? upper_line[ci] : '0;
    md = (ri >= 1 && ri <= h) ? middle_line[ci] : '0;
    upper_line[ci]  = md;
    middle_line[ci] = nv;
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = md;
    win[2][2] = nv;
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) taps[r][c] = win[r][c];
    end
    if (ci >= 1) begin
      hit      = (ri >= 1 && ri <= h);
      last_col = (ci == w);
      last_row = (ri == h);
      if (ci == 1) begin
        for (r = 0; r < 3; r++) taps[r][0] = 0;
      end
    end else begin
      hit      = (ri >= 2);
      last_col = 1'b1;
      last_row = (ri == h + 1);
      for (r = 0; r < 3; r++) taps[r][2] = 0;
      if (w < 2) begin
        for (r = 0; r < 3; r++) taps[r][0] = 0;
      end
    end
    if (ci + 1 >= w) begin
      col_pos = 0;
      row_pos = ri + 1;
    end else begin
      col_pos = ci + 1;
    end
    if (!hit) return 1'b0;
    gx = (taps[0][2] + 2 * taps[1][2] + taps[2][2]) - (taps[0][0] + 2 * taps[1][0] + taps[2][0]);
    gy = (taps[2][0] + 2 * taps[2][1] + taps[2][2]) - (taps[0][0] + 2 * taps[0][1] + taps[0][2]);
    res.magnitude = floor_root(gx * gx + gy * gy);
    res.row_end   = last_col;
    res.frame_end = last_col && last_row;
    if (res.frame_end) begin
      col_pos = 0;
      row_pos = 0;
      frames_closed++;
    end
    return 1'b1;
  endfunction

  function automatic logic [sem_pkg::GREEN_W-1:0] pick_green();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return sem_pkg::GREEN_W'($urandom_range(255));
  endfunction

  task automatic send_item(input logic kind, input logic [sem_pkg::GREEN_W-1:0] green);
    edge_result_t want;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      pix_if.kind  <= 1'($urandom_range(1));
      pix_if.green <= sem_pkg::GREEN_W'($urandom_range(255));
      @(negedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.kind  <= kind;
    pix_if.green <= green;
    do @(posedge clk); while (!pix_if.ready);
    pixels_sent++;
    if (sobel_advance(kind, green, want)) due_gradients.push_back(want);
  endtask

  // Send raster positions first_pos up to, but not including, end_pos of the current frame.
  task automatic send_raster(input int first_pos, input int end_pos);
    int image_items;
    int pos;
    logic kind;
    image_items = eff_cols() * eff_rows();
    for (pos = first_pos; pos < end_pos; pos++) begin
      if (pos < image_items) begin
        kind = ($urandom_range(99) < WELL_FORMED_PCT) ? sem_pkg::KIND_PIXEL : sem_pkg::KIND_FLUSH;
      end else begin
        kind = ($urandom_range(99) < WELL_FORMED_PCT) ? sem_pkg::KIND_FLUSH : sem_pkg::KIND_PIXEL;
      end
      send_item(kind, pick_green());
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (due_gradients.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sem_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [sem_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      sem_pkg::REG_IMAGE_WIDTH: begin
        width_shadow = data[sem_pkg::WIDTH_REG_W-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      sem_pkg::REG_IMAGE_HEIGHT: begin
        height_shadow = data[sem_pkg::HEIGHT_REG_W-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we   <= 1'b0;
    cfg_data <= sem_pkg::CFG_DATA_W'($urandom_range(2 ** sem_pkg::CFG_DATA_W - 1));
  endtask

  task automatic test_reset_defaults();
    send_idle_pct = 0;
    stall_pct = 0;
    send_raster(0, eff_cols() + 4);
  endtask

  task automatic test_directed_cases();
    logic [sem_pkg::GREEN_W-1:0] tile [9];
    int i;
    tile = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    wait_idle();
    write_reg(sem_pkg::REG_IMAGE_WIDTH, 3);
    write_reg(sem_pkg::REG_IMAGE_HEIGHT, 3);
    // flush in the middle of the image reads as zero
    for (i = 0; i < 9; i++) begin
      send_item((i == 4) ? sem_pkg::KIND_FLUSH : sem_pkg::KIND_PIXEL, tile[i]);
    end
    // pixel past the last row reads as flush
    for (i = 0; i < 4; i++) begin
      send_item((i == 1) ? sem_pkg::KIND_PIXEL : sem_pkg::KIND_FLUSH, 8'hFF);
    end
    wait_idle();
    write_reg(sem_pkg::REG_IMAGE_WIDTH, 0);
    write_reg(sem_pkg::REG_IMAGE_HEIGHT, 0);
    send_item(sem_pkg::KIND_PIXEL, 8'hFF);
    send_item(sem_pkg::KIND_FLUSH, 8'h00);
    send_item(sem_pkg::KIND_FLUSH, 8'hFF);
    send_item(sem_pkg::KIND_PIXEL, 8'h00);
    send_item(sem_pkg::KIND_PIXEL, 8'hFF);
    send_item(sem_pkg::KIND_FLUSH, 8'h5A);
  endtask

  task automatic test_pressure();
    send_idle_pct = 0;
    stall_pct = 0;
    wait_idle();
    write_reg(sem_pkg::REG_IMAGE_WIDTH, 16);
    write_reg(sem_pkg::REG_IMAGE_HEIGHT, 4);
    holds_requested++;
    send_raster(0, 30);
    wait_idle();
    send_raster(30, frame_len());
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_in, input int quota);
    int start_count;
    int width_val;
    int height_val;
    int total;
    int cut;
    bit mid_frame;
    logic [sem_pkg::CFG_DATA_W-1:0] wdata;
    send_idle_pct = idle_pct;
    stall_pct = stall_in;
    start_count = pixels_sent;
    mid_frame = 1'b1;
    while (pixels_sent - start_count < quota) begin
      if (mid_frame || $urandom_range(3) != 0) begin
        width_val = ($urandom_range(99) < 8)  ? 0 :
                    ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        height_val = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 6);
        wdata = sem_pkg::CFG_DATA_W'(width_val);
        wdata[sem_pkg::CFG_DATA_W-1] = 1'($urandom_range(1));
        wait_idle();
        if ($urandom_range(1)) begin
          write_reg(sem_pkg::REG_IMAGE_WIDTH, wdata);
          write_reg(sem_pkg::REG_IMAGE_HEIGHT, sem_pkg::CFG_DATA_W'(height_val));
        end else begin
          write_reg(sem_pkg::REG_IMAGE_HEIGHT, sem_pkg::CFG_DATA_W'(height_val));
          write_reg(sem_pkg::REG_IMAGE_WIDTH, wdata);
        end
      end
      total = frame_len();
      cut = ($urandom_range(9) == 0) ? $urandom_range(1, total - 1) : total;
      send_raster(0, cut);
      mid_frame = (cut != total);
      if (mid_frame && $urandom_range(1)) begin
        wait_idle();
        write_reg(REG_SPARE,
                  sem_pkg::CFG_DATA_W'($urandom_range(2 ** sem_pkg::CFG_DATA_W - 1)));
        send_raster(cut, total);
        mid_frame = 1'b0;
      end
    end
    wait_idle();
  endtask

  task automatic test_register_extremes();
    int unsigned ext_w [4];
    int unsigned ext_h [4];
    int i;
    ext_w = '{4095, 0, 2048, 1};
    ext_h = '{0, 8191, 1, 4096};
    send_idle_pct = 0;
    stall_pct = 0;
    for (i = 0; i < 4; i++) begin
      wait_idle();
      write_reg(sem_pkg::REG_IMAGE_WIDTH, sem_pkg::CFG_DATA_W'(ext_w[i]));
      write_reg(sem_pkg::REG_IMAGE_HEIGHT, sem_pkg::CFG_DATA_W'(ext_h[i]));
      send_raster(0, EXTREME_ITEMS);
    end
  endtask

  initial begin : result_sink
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_requested) begin
        holds_served = holds_requested;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : gradient_check
    edge_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (due_gradients.size() == 0) begin
        flag_mismatch($sformatf("magnitude %0d with nothing outstanding", res_if.magnitude));
      end else begin
        want = due_gradients.pop_front();
        gradients_checked++;
        if (res_if.magnitude !== want.magnitude) begin
          flag_mismatch($sformatf("gradient %0d magnitude %0d, want %0d", gradients_checked,
                                  res_if.magnitude, want.magnitude));
        end
        if (res_if.row_end !== want.row_end) begin
          flag_mismatch($sformatf("gradient %0d row_end %b, want %b", gradients_checked,
                                  res_if.row_end, want.row_end));
        end
        if (res_if.frame_end !== want.frame_end) begin
          flag_mismatch($sformatf("gradient %0d frame_end %b, want %b", gradients_checked,
                                  res_if.frame_end, want.frame_end));
        end
      end
    end
  end

  initial begin
    int i, r, c;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = sem_pkg::REG_IMAGE_WIDTH;
    cfg_data = '0;
    pix_if.valid = 1'b0;
    pix_if.kind = sem_pkg::KIND_PIXEL;
    pix_if.green = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    holds_requested = 0;
    pixels_sent = 0;
    gradients_checked = 0;
    frames_closed = 0;
    mismatch_count = 0;
    width_shadow = sem_pkg::WIDTH_RESET;
    height_shadow = sem_pkg::HEIGHT_RESET;
    col_pos = 0;
    row_pos = 0;
    for (i = 0; i < MAX_LINE; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) win[r][c] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_cases();
    test_pressure();
    test_random_traffic(0, 0, 30);
    test_random_traffic(61, 0, 30);
    test_random_traffic(0, 61, 30);
    test_random_traffic(31, 31, 30);
    test_register_extremes();
    wait_idle();

    $display("Sent %0d pixel and flush requests, checked %0d gradients over %0d frames.",
             pixels_sent, gradients_checked, frames_closed);
    $display("Default 640-wide rows, small random frames, clamped and truncated sizes, stalls.");
    if (mismatch_count == 0 && due_gradients.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sem_pkg.sv
hw/rtl/sem_in_if.sv
hw/rtl/sem_out_if.sv
hw/rtl/sem_datapath.sv
hw/rtl/sem_controller.sv
hw/rtl/sobel_edge_magnitude_core.sv
hw/rtl/sem_checker.sv
verif/sobel_edge_magnitude_core_tb.sv
